// ===== src/slide_servo_kinematics_defines.svh =====
// assertion helpers for the slide servo kinematics block
`ifndef SLIDE_SERVO_KINEMATICS_DEFINES_SVH
`define SLIDE_SERVO_KINEMATICS_DEFINES_SVH

// property that must hold in the same cycle
`define SSK_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property whose consequence is checked in the cycle after the antecedent
`define SSK_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);

`endif

// ===== src/ssk_pkg.sv =====
`default_nettype none

package ssk_pkg;

  localparam int unsigned ACOS_DEPTH    = 256;
  localparam int unsigned FRAC_BITS     = 14;
  localparam int unsigned FW            = FRAC_BITS + 1;
  localparam int unsigned ONE           = 2 ** FRAC_BITS;
  localparam int unsigned KW            = $clog2(ACOS_DEPTH + 1);
  localparam int unsigned DEPTH_LOG2    = $clog2(ACOS_DEPTH);
  localparam int unsigned QPO_W         = FRAC_BITS + 2;
  localparam int unsigned P_W           = QPO_W + KW;
  localparam int unsigned ANGLE_W       = 12;
  localparam int unsigned PW_W          = 12;
  localparam int unsigned ACOS_TAB_W    = (ACOS_DEPTH + 1) * ANGLE_W;
  localparam int unsigned CORDIC_STEPS  = 20;
  localparam int unsigned CORDIC_SCALE  = 24;
  localparam longint      HALF_PI_URAD  = 1570796;
  localparam longint      PI_URAD       = 3141592;
  // microradians to milliradians by reciprocal, exact up to pi
  localparam longint      MRAD_RECIP    = 4294968;
  localparam int unsigned MRAD_SHIFT    = 32;
  localparam int unsigned PW_MAX        = 4095;
  // degrees to end-angle units, 175/10 taken as 35/2
  localparam int unsigned DEG_SCALE2    = 35;

  localparam int unsigned LEN_W   = 14;
  localparam int unsigned DEG_W   = 8;
  localparam int unsigned C_W     = 16;
  localparam int unsigned CP_W    = 15;
  localparam int unsigned CC_W    = 30;
  localparam int unsigned SQ_W    = 28;
  localparam int unsigned BC_W    = 29;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned DEN_W   = 30;
  localparam int unsigned RREM_W  = DEN_W + 1;
  localparam int unsigned DIFF_W  = ANGLE_W + 1;
  localparam int unsigned IPROD_W = DIFF_W + FW + 1;
  localparam int unsigned AMIN_W  = 13;
  localparam int unsigned PDV_W   = 13;
  localparam int unsigned PREM_W  = PDV_W + 1;
  localparam int unsigned PQ_W    = 25;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_CLAMP = 2'd1,
    FAULT_SIDE  = 2'd2
  } fault_e;

  typedef struct packed {
    logic [CC_W-1:0] cc;
    logic [SQ_W-1:0] bb;
    logic [SQ_W-1:0] aa;
    logic [BC_W-1:0] bc;
    logic            side;
  } front_t;

  typedef struct packed {
    logic   neg;
    logic   sat;
    fault_e fault;
  } ratio_side_t;

  typedef struct packed {
    logic [RREM_W-1:0] rem;
    logic [DEN_W-1:0]  den;
    ratio_side_t       side;
  } ratio_in_t;

  typedef struct packed {
    logic [KW-1:0] k;
    logic [FW-1:0] f;
    fault_e        fault;
  } idx_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]       t0;
    logic signed [DIFF_W-1:0] diff;
    logic [FW-1:0]            f;
    fault_e                   fault;
  } tab_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        t0;
    logic signed [IPROD_W-1:0] prod;
    fault_e                    fault;
  } prod_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    fault_e             fault;
  } ang_t;

  typedef struct packed {
    logic               neg;
    logic               dxz;
    fault_e             fault;
    logic [ANGLE_W-1:0] angle;
  } pulse_side_t;

  typedef struct packed {
    logic [1:0][PQ_W-1:0] n;
    logic [PDV_W-1:0]     dvs;
    pulse_side_t          side;
  } pulse_in_t;

  typedef struct packed {
    logic [PW_W-1:0]    pulse_width;
    logic [ANGLE_W-1:0] servo_angle;
    fault_e             fault;
  } out_t;

  function automatic longint atan_urad(input int unsigned i);
    longint r;
    case (i)
      0:       r = 785398;
      1:       r = 463648;
      2:       r = 244979;
      3:       r = 124355;
      4:       r = 62419;
      5:       r = 31240;
      6:       r = 15624;
      7:       r = 7812;
      8:       r = 3906;
      9:       r = 1953;
      10:      r = 977;
      11:      r = 488;
      12:      r = 244;
      13:      r = 122;
      14:      r = 61;
      15:      r = 31;
      16:      r = 15;
      17:      r = 8;
      18:      r = 4;
      default: r = 2;
    endcase
    return r;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned bv;
    longint unsigned rm;
    r  = 0;
    rm = v;
    bv = longint'(1) << 62;
    while (bv > rm) bv = bv >> 2;
    while (bv != 0) begin
      if (rm >= r + bv) begin
        rm = rm - (r + bv);
        r  = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // arccosine table in milliradians, built by vectoring cordic at elaboration
  function automatic logic [ACOS_TAB_W-1:0] acos_table();
    logic [ACOS_TAB_W-1:0] tab;
    longint s, x, y, z, t, xs, ys;
    tab = '0;
    s   = longint'(1) << CORDIC_SCALE;
    for (int k = 0; k <= int'(ACOS_DEPTH); k++) begin
      // exact, the depth divides the scale
      x = ((2 * longint'(k) - longint'(ACOS_DEPTH)) * s) >>> DEPTH_LOG2;
      y = longint'(isqrt64(longint'(s * s - x * x)));
      z = 0;
      if (x < 0) begin
        t = y;
        y = -x;
        x = t;
        z = HALF_PI_URAD;
      end
      for (int i = 0; i < int'(CORDIC_STEPS); i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_urad(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_urad(i);
        end
      end
      if (z < 0) z = 0;
      if (z > PI_URAD) z = PI_URAD;
      tab[ANGLE_W*k +: ANGLE_W] = ANGLE_W'((z * MRAD_RECIP) >>> MRAD_SHIFT);
    end
    return tab;
  endfunction

  localparam logic [ACOS_TAB_W-1:0] ACOS_TAB = acos_table();

endpackage

`default_nettype wire

// ===== src/ssk_reg_stage.sv =====
`default_nettype none

module ssk_reg_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/ssk_div_cell.sv =====
`default_nettype none

// one restoring division step per cell, lanes share the divisor
module ssk_div_cell #(
  parameter int unsigned NL = 1,
  parameter int unsigned AW = 4,
  parameter int unsigned QW = 4,
  parameter int unsigned SW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [NL-1:0][AW-1:0]  rem_i,
  input  logic [NL-1:0][QW-1:0]  quo_i,
  input  logic [AW-2:0]          dvs_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [NL-1:0][AW-1:0]  rem_o,
  output logic [NL-1:0][QW-1:0]  quo_o,
  output logic [AW-2:0]          dvs_o,
  output logic [SW-1:0]          side_o
);

  logic                  valid_q;
  logic [NL-1:0][AW-1:0] rem_d, rem_q;
  logic [NL-1:0][QW-1:0] quo_d, quo_q;
  logic [AW-2:0]         dvs_q;
  logic [SW-1:0]         side_q;
  logic [NL-1:0][AW-1:0] trial;

  always_comb begin
    for (int l = 0; l < int'(NL); l++) begin
      trial[l] = {rem_i[l][AW-2:0], quo_i[l][QW-1]};
      if (trial[l] >= {1'b0, dvs_i}) begin
        rem_d[l] = trial[l] - {1'b0, dvs_i};
        quo_d[l] = {quo_i[l][QW-2:0], 1'b1};
      end else begin
        rem_d[l] = trial[l];
        quo_d[l] = {quo_i[l][QW-2:0], 1'b0};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign dvs_o   = dvs_q;
  assign side_o  = side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_i;
      side_q <= side_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/slide_servo_kinematics.sv =====
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------
// request   | in_valid_i / in_stall_o    | position_i
// result    | out_valid_o / out_stall_i  | pulse_width_o, servo_angle_o, fault_o
// config    | psel, penable, pwrite      | paddr, pwdata, prdata
//
// one request per cycle unless an output stall backs the pipeline up
// the pipeline length is set by the 14-cell ratio divider row and the
// 25-cell pulse divider row, one quotient bit per cell
// reset clears all stage valids and loads the register defaults, no clearing pass
// a stall only holds stages that are full, bubbles still close up
`default_nettype none

module slide_servo_kinematics (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [14:0]     position_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [11:0]            pulse_width_o,
  output logic [11:0]            servo_angle_o,
  output logic [1:0]             fault_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    REG_SERVO_ARM = 3'd0,
    REG_SLIDE_ARM = 3'd1,
    REG_MAX_DEG   = 3'd2,
    REG_MIN_DEG   = 3'd3,
    REG_PULSE_MAX = 3'd4,
    REG_PULSE_MIN = 3'd5
  } reg_idx_e;

  localparam int unsigned NR = ssk_pkg::FRAC_BITS;
  localparam int unsigned NP = ssk_pkg::PQ_W;

  // configuration registers
  logic [ssk_pkg::LEN_W-1:0]   servo_arm_q, slide_arm_q;
  logic [ssk_pkg::DEG_W-1:0]   max_deg_q, min_deg_q;
  logic [ssk_pkg::PW_W-1:0]    pulse_max_q, pulse_min_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_arm_q <= 14'd1000;
      slide_arm_q <= 14'd2000;
      max_deg_q   <= 8'd150;
      min_deg_q   <= 8'd30;
      pulse_max_q <= 12'd2350;
      pulse_min_q <= 12'd650;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_SERVO_ARM: servo_arm_q <= pwdata[ssk_pkg::LEN_W-1:0];
        REG_SLIDE_ARM: slide_arm_q <= pwdata[ssk_pkg::LEN_W-1:0];
        REG_MAX_DEG:   max_deg_q   <= pwdata[ssk_pkg::DEG_W-1:0];
        REG_MIN_DEG:   min_deg_q   <= pwdata[ssk_pkg::DEG_W-1:0];
        REG_PULSE_MAX: pulse_max_q <= pwdata[ssk_pkg::PW_W-1:0];
        REG_PULSE_MIN: pulse_min_q <= pwdata[ssk_pkg::PW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_SERVO_ARM: prdata = 32'(servo_arm_q);
      REG_SLIDE_ARM: prdata = 32'(slide_arm_q);
      REG_MAX_DEG:   prdata = 32'(max_deg_q);
      REG_MIN_DEG:   prdata = 32'(min_deg_q);
      REG_PULSE_MAX: prdata = 32'(pulse_max_q);
      REG_PULSE_MIN: prdata = 32'(pulse_min_q);
      default:       prdata = '0;
    endcase
  end

  // side c and the squares
  logic signed [ssk_pkg::C_W-1:0] c_s;
  logic [ssk_pkg::CP_W-1:0]       c_pos;
  ssk_pkg::front_t                front_d, front_q;
  logic                           in_ready, front_v, front_rdy;

  assign c_s   = ssk_pkg::C_W'(position_i) + $signed({2'b00, servo_arm_q});
  assign c_pos = c_s[ssk_pkg::CP_W-1:0];

  always_comb begin
    front_d.side = (c_s <= 16'sd0) || (slide_arm_q == '0);
    front_d.cc   = ssk_pkg::CC_W'(c_pos) * ssk_pkg::CC_W'(c_pos);
    front_d.bb   = ssk_pkg::SQ_W'(slide_arm_q) * ssk_pkg::SQ_W'(slide_arm_q);
    front_d.aa   = ssk_pkg::SQ_W'(servo_arm_q) * ssk_pkg::SQ_W'(servo_arm_q);
    front_d.bc   = ssk_pkg::BC_W'(slide_arm_q) * ssk_pkg::BC_W'(c_pos);
  end

  assign in_stall_o = !in_ready;

  ssk_reg_stage #(.W($bits(ssk_pkg::front_t))) u_st_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready), .data_i(front_d),
    .valid_o(front_v), .ready_i(front_rdy), .data_o(front_q)
  );

  // numerator, denominator and clamp
  logic signed [ssk_pkg::NUM_W-1:0] num;
  logic [ssk_pkg::NUM_W-1:0]        num_abs;
  logic [ssk_pkg::RREM_W-1:0]       mag;
  logic [ssk_pkg::DEN_W-1:0]        den;
  logic                             clamp, hit_one;
  ssk_pkg::ratio_in_t               rin_d, rin_q;
  logic                             rin_v;

  always_comb begin
    num     = $signed({2'b00, front_q.cc}) + $signed({4'b0000, front_q.bb})
              - $signed({4'b0000, front_q.aa});
    num_abs = num[ssk_pkg::NUM_W-1] ? ssk_pkg::NUM_W'(-num) : ssk_pkg::NUM_W'(num);
    mag     = num_abs[ssk_pkg::RREM_W-1:0];
    den     = {front_q.bc, 1'b0};
    clamp   = mag > {1'b0, den};
    hit_one = mag == {1'b0, den};
    rin_d.rem      = (clamp || hit_one) ? '0 : mag;
    rin_d.den      = den;
    rin_d.side.neg = num[ssk_pkg::NUM_W-1];
    rin_d.side.sat = clamp || hit_one;
    if (front_q.side) begin
      rin_d.side.fault = ssk_pkg::FAULT_SIDE;
    end else if (clamp) begin
      rin_d.side.fault = ssk_pkg::FAULT_CLAMP;
    end else begin
      rin_d.side.fault = ssk_pkg::FAULT_OK;
    end
  end

  logic                           r_valid [NR+1];
  logic                           r_ready [NR+1];
  logic [ssk_pkg::RREM_W-1:0]     r_rem   [NR+1];
  logic [ssk_pkg::FRAC_BITS-1:0]  r_quo   [NR+1];
  logic [ssk_pkg::DEN_W-1:0]      r_dvs   [NR+1];
  ssk_pkg::ratio_side_t           r_side  [NR+1];

  ssk_reg_stage #(.W($bits(ssk_pkg::ratio_in_t))) u_st_ratio_in (
    .clk_i, .rst_ni,
    .valid_i(front_v), .ready_o(front_rdy), .data_i(rin_d),
    .valid_o(rin_v), .ready_i(r_ready[0]), .data_o(rin_q)
  );

  assign r_valid[0] = rin_v;
  assign r_rem[0]   = rin_q.rem;
  assign r_quo[0]   = '0;
  assign r_dvs[0]   = rin_q.den;
  assign r_side[0]  = rin_q.side;

  for (genvar i = 0; i < NR; i++) begin : g_ratio
    ssk_div_cell #(
      .NL(1), .AW(ssk_pkg::RREM_W), .QW(ssk_pkg::FRAC_BITS),
      .SW($bits(ssk_pkg::ratio_side_t))
    ) u_cell (
      .clk_i, .rst_ni,
      .valid_i(r_valid[i]), .ready_o(r_ready[i]),
      .rem_i(r_rem[i]), .quo_i(r_quo[i]), .dvs_i(r_dvs[i]), .side_i(r_side[i]),
      .valid_o(r_valid[i+1]), .ready_i(r_ready[i+1]),
      .rem_o(r_rem[i+1]), .quo_o(r_quo[i+1]), .dvs_o(r_dvs[i+1]), .side_o(r_side[i+1])
    );
  end

  // table index and fraction
  logic [ssk_pkg::FW-1:0]    qm;
  logic [ssk_pkg::QPO_W-1:0] qpo;
  logic [ssk_pkg::P_W-1:0]   p;
  ssk_pkg::idx_t             idx_d, idx_q;
  logic                      idx_v, idx_rdy;

  always_comb begin
    qm  = r_side[NR].sat ? ssk_pkg::FW'(ssk_pkg::ONE) : {1'b0, r_quo[NR]};
    qpo = r_side[NR].neg ? ssk_pkg::QPO_W'(ssk_pkg::ONE) - ssk_pkg::QPO_W'(qm)
                         : ssk_pkg::QPO_W'(ssk_pkg::ONE) + ssk_pkg::QPO_W'(qm);
    p   = ssk_pkg::P_W'(qpo) * ssk_pkg::P_W'(ssk_pkg::ACOS_DEPTH);
    idx_d.k     = p[ssk_pkg::FW +: ssk_pkg::KW];
    idx_d.f     = p[ssk_pkg::FW-1:0];
    idx_d.fault = r_side[NR].fault;
  end

  ssk_reg_stage #(.W($bits(ssk_pkg::idx_t))) u_st_idx (
    .clk_i, .rst_ni,
    .valid_i(r_valid[NR]), .ready_o(r_ready[NR]), .data_i(idx_d),
    .valid_o(idx_v), .ready_i(idx_rdy), .data_o(idx_q)
  );

  // table read
  logic [ssk_pkg::KW-1:0]      k_next;
  logic [ssk_pkg::ANGLE_W-1:0] t0, t1;
  ssk_pkg::tab_t               tab_d, tab_q;
  logic                        tab_v, tab_rdy;

  always_comb begin
    k_next = idx_q.k + 1'b1;
    if (idx_q.k >= ssk_pkg::KW'(ssk_pkg::ACOS_DEPTH)) begin
      t0 = ssk_pkg::ACOS_TAB[ssk_pkg::ANGLE_W*ssk_pkg::ACOS_DEPTH +: ssk_pkg::ANGLE_W];
      t1 = t0;
    end else begin
      t0 = ssk_pkg::ACOS_TAB[ssk_pkg::ANGLE_W*idx_q.k +: ssk_pkg::ANGLE_W];
      t1 = ssk_pkg::ACOS_TAB[ssk_pkg::ANGLE_W*k_next +: ssk_pkg::ANGLE_W];
    end
    tab_d.t0    = t0;
    tab_d.diff  = $signed({1'b0, t1}) - $signed({1'b0, t0});
    tab_d.f     = idx_q.f;
    tab_d.fault = idx_q.fault;
  end

  ssk_reg_stage #(.W($bits(ssk_pkg::tab_t))) u_st_tab (
    .clk_i, .rst_ni,
    .valid_i(idx_v), .ready_o(idx_rdy), .data_i(tab_d),
    .valid_o(tab_v), .ready_i(tab_rdy), .data_o(tab_q)
  );

  // interpolation product
  ssk_pkg::prod_t prod_d, prod_q;
  logic           prod_v, prod_rdy;

  always_comb begin
    prod_d.t0    = tab_q.t0;
    prod_d.prod  = ssk_pkg::IPROD_W'(tab_q.diff)
                   * ssk_pkg::IPROD_W'($signed({1'b0, tab_q.f}));
    prod_d.fault = tab_q.fault;
  end

  ssk_reg_stage #(.W($bits(ssk_pkg::prod_t))) u_st_prod (
    .clk_i, .rst_ni,
    .valid_i(tab_v), .ready_o(tab_rdy), .data_i(prod_d),
    .valid_o(prod_v), .ready_i(prod_rdy), .data_o(prod_q)
  );

  // angle, truncating toward zero
  logic                             ip_neg;
  logic signed [ssk_pkg::IPROD_W-1:0] ip_abs, ip_sh, ip_adj, ang_sum;
  ssk_pkg::ang_t                    ang_d, ang_q;
  logic                             ang_v, ang_rdy;

  always_comb begin
    ip_neg  = prod_q.prod[ssk_pkg::IPROD_W-1];
    ip_abs  = ip_neg ? -prod_q.prod : prod_q.prod;
    ip_sh   = ip_abs >>> ssk_pkg::FW;
    ip_adj  = ip_neg ? -ip_sh : ip_sh;
    ang_sum = ssk_pkg::IPROD_W'($signed({1'b0, prod_q.t0})) + ip_adj;
    ang_d.angle = ang_sum[ssk_pkg::ANGLE_W-1:0];
    ang_d.fault = prod_q.fault;
  end

  ssk_reg_stage #(.W($bits(ssk_pkg::ang_t))) u_st_ang (
    .clk_i, .rst_ni,
    .valid_i(prod_v), .ready_o(prod_rdy), .data_i(ang_d),
    .valid_o(ang_v), .ready_i(ang_rdy), .data_o(ang_q)
  );

  // pulse mapping operands
  logic [13:0]                      amin_x, amax_x;
  logic [ssk_pkg::AMIN_W-1:0]       amin, amax;
  logic signed [ssk_pkg::AMIN_W:0]  dx;
  logic [ssk_pkg::AMIN_W:0]         dx_abs;
  logic signed [ssk_pkg::PW_W:0]    dy;
  logic [ssk_pkg::PW_W:0]           dy_abs;
  ssk_pkg::pulse_in_t               pin_d, pin_q;
  logic                             pin_v;

  always_comb begin
    amin_x = 14'(min_deg_q) * 14'(ssk_pkg::DEG_SCALE2);
    amax_x = 14'(max_deg_q) * 14'(ssk_pkg::DEG_SCALE2);
    amin   = amin_x[13:1];
    amax   = amax_x[13:1];
    dx     = $signed({1'b0, amax}) - $signed({1'b0, amin});
    dx_abs = dx[ssk_pkg::AMIN_W] ? 14'(-dx) : 14'(dx);
    dy     = $signed({1'b0, pulse_max_q}) - $signed({1'b0, pulse_min_q});
    dy_abs = dy[ssk_pkg::PW_W] ? 13'(-dy) : 13'(dy);
    pin_d.n[0]       = ssk_pkg::PQ_W'(dy_abs[ssk_pkg::PW_W-1:0])
                       * ssk_pkg::PQ_W'(ang_q.angle);
    pin_d.n[1]       = ssk_pkg::PQ_W'(dy_abs[ssk_pkg::PW_W-1:0])
                       * ssk_pkg::PQ_W'(amin);
    pin_d.dvs        = dx_abs[ssk_pkg::PDV_W-1:0];
    pin_d.side.neg   = dy[ssk_pkg::PW_W] ^ dx[ssk_pkg::AMIN_W];
    pin_d.side.dxz   = (dx == '0);
    pin_d.side.fault = ang_q.fault;
    pin_d.side.angle = ang_q.angle;
  end

  logic                               p_valid [NP+1];
  logic                               p_ready [NP+1];
  logic [1:0][ssk_pkg::PREM_W-1:0]    p_rem   [NP+1];
  logic [1:0][ssk_pkg::PQ_W-1:0]      p_quo   [NP+1];
  logic [ssk_pkg::PDV_W-1:0]          p_dvs   [NP+1];
  ssk_pkg::pulse_side_t               p_side  [NP+1];

  ssk_reg_stage #(.W($bits(ssk_pkg::pulse_in_t))) u_st_pulse_in (
    .clk_i, .rst_ni,
    .valid_i(ang_v), .ready_o(ang_rdy), .data_i(pin_d),
    .valid_o(pin_v), .ready_i(p_ready[0]), .data_o(pin_q)
  );

  assign p_valid[0] = pin_v;
  assign p_rem[0]   = '0;
  assign p_quo[0]   = pin_q.n;
  assign p_dvs[0]   = pin_q.dvs;
  assign p_side[0]  = pin_q.side;

  for (genvar i = 0; i < NP; i++) begin : g_pulse
    ssk_div_cell #(
      .NL(2), .AW(ssk_pkg::PREM_W), .QW(ssk_pkg::PQ_W),
      .SW($bits(ssk_pkg::pulse_side_t))
    ) u_cell (
      .clk_i, .rst_ni,
      .valid_i(p_valid[i]), .ready_o(p_ready[i]),
      .rem_i(p_rem[i]), .quo_i(p_quo[i]), .dvs_i(p_dvs[i]), .side_i(p_side[i]),
      .valid_o(p_valid[i+1]), .ready_i(p_ready[i+1]),
      .rem_o(p_rem[i+1]), .quo_o(p_quo[i+1]), .dvs_o(p_dvs[i+1]), .side_o(p_side[i+1])
    );
  end

  // pulse assembly and saturation
  logic signed [ssk_pkg::PQ_W:0]   qd, qv;
  logic signed [ssk_pkg::PQ_W+2:0] pw_raw;
  ssk_pkg::out_t                   out_d, out_q;
  logic                            out_rdy;

  always_comb begin
    qd     = $signed({1'b0, p_quo[NP][0]}) - $signed({1'b0, p_quo[NP][1]});
    qv     = p_side[NP].neg ? -qd : qd;
    pw_raw = (ssk_pkg::PQ_W+3)'(qv) + $signed({16'd0, pulse_min_q});
    if (p_side[NP].dxz) begin
      out_d.pulse_width = pulse_min_q;
    end else if (pw_raw < 0) begin
      out_d.pulse_width = '0;
    end else if (pw_raw > $signed((ssk_pkg::PQ_W+3)'(ssk_pkg::PW_MAX))) begin
      out_d.pulse_width = ssk_pkg::PW_W'(ssk_pkg::PW_MAX);
    end else begin
      out_d.pulse_width = pw_raw[ssk_pkg::PW_W-1:0];
    end
    out_d.servo_angle = p_side[NP].angle;
    out_d.fault       = p_side[NP].fault;
    if (p_side[NP].fault == ssk_pkg::FAULT_SIDE) begin
      out_d.pulse_width = '0;
      out_d.servo_angle = '0;
    end
  end

  assign out_rdy = !out_stall_i;

  ssk_reg_stage #(.W($bits(ssk_pkg::out_t))) u_st_out (
    .clk_i, .rst_ni,
    .valid_i(p_valid[NP]), .ready_o(p_ready[NP]), .data_i(out_d),
    .valid_o(out_valid_o), .ready_i(out_rdy), .data_o(out_q)
  );

  assign pulse_width_o = out_q.pulse_width;
  assign servo_angle_o = out_q.servo_angle;
  assign fault_o       = out_q.fault;

endmodule

`default_nettype wire

// ===== src/ssk_checker.sv =====
`default_nettype none

`include "slide_servo_kinematics_defines.svh"

module ssk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] pulse_width_o,
  input logic [11:0] servo_angle_o,
  input logic [1:0]  fault_o
);

  // a held result keeps its payload
  `SSK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pulse_width_o) && $stable(servo_angle_o) && $stable(fault_o), "stalled result changed")

  // the input only backs up when the output is held
  `SSK_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with output free")

  // bad triangle gives zero outputs
  `SSK_ASSERT(a_side_zero, clk_i, rst_ni, out_valid_o && fault_o == ssk_pkg::FAULT_SIDE |-> pulse_width_o == 12'd0 && servo_angle_o == 12'd0, "side fault with non-zero output")

  // angle stays within half a turn
  `SSK_ASSERT(a_angle_range, clk_i, rst_ni, out_valid_o |-> servo_angle_o <= 12'd3142, "angle out of range")

endmodule

bind slide_servo_kinematics ssk_checker u_checker (.*);

`default_nettype wire
